### src/sps_pkg.sv
// Package for the sorted slotted page store: item types, codes and sequencer states.
package sps_pkg;

  localparam int SLOT_DEPTH = 256;
  localparam int CELL_HDR   = 12;
  localparam int LEN_AT     = 8;

  localparam logic [2:0] ACT_INIT   = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_VALUE  = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_LOWER  = 3'd4;
  localparam logic [2:0] ACT_READ   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADIDX  = 2'd2;
  localparam logic [1:0] ST_NOFILL  = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] key;
    logic [12:0] value_len;
    logic [7:0]  data_byte;
    logic [7:0]  index;
    logic [11:0] byte_offset;
    logic [31:0] parent_page;
    logic [31:0] next_page;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  position;
    logic [63:0] key_out;
    logic [12:0] length_out;
    logic [7:0]  byte_out;
    logic [7:0]  entry_count;
    logic [12:0] heap_start;
    logic [31:0] parent_out;
    logic [31:0] next_out;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CLEAR, S_LB_START, S_SLOT_WAIT, S_FETCH, S_LB_CMP,
    S_READ_CHK, S_BYTE_WAIT, S_HDR_WR, S_SHR, S_SHR_WR, S_SHL, S_SHL_WR, S_DONE
  } state_t;

endpackage

### src/sorted_slotted_page_store.sv
// Sorted slotted leaf page: sequencer, cell heap and slot array.
// Value byte, bad index, failed insert end at decode; delete shifts the later slots down;
//   lower bound fetches a cell header per step (at most 8); read fetches header, then byte.
// Insert searches, writes the header, shifts slots; init clears the page via one heap port.
// Throughput: one item at a time; a new beat is taken while a result still waits.
// Reset: rst clears count, heap end, page numbers and fill state; memories stay undefined.
module sorted_slotted_page_store #(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 17,
  parameter int SLOT_BYTES   = 4,
  parameter int MAX_ENTRIES  = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sps_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sps_pkg::rsp_t rsp
);
  import sps_pkg::*;

  localparam int AW        = $clog2(PAGE_BYTES);
  localparam int FW        = $clog2(PAGE_BYTES + 1);
  localparam int COUNT_CAP = (MAX_ENTRIES < 255) ? MAX_ENTRIES : 255;
  localparam logic [FW-1:0] PAGE_END = FW'(PAGE_BYTES);

  // Storage: byte heap and slot array, one write and one registered read port each.
  logic [7:0]    heap [PAGE_BYTES];
  logic [FW-1:0] slots [SLOT_DEPTH];
  logic [7:0]    heap_q;
  logic [FW-1:0] slot_q;

  logic          heap_we, slot_we;
  logic [AW-1:0] heap_wa, heap_ra;
  logic [7:0]    heap_wd;
  logic [7:0]    slot_wa, slot_ra;
  logic [FW-1:0] slot_wd;

  state_t state, state_next;
  req_t   cur;

  // Page state.
  logic [8:0]    lc;
  logic [FW-1:0] free_end;
  logic [31:0]   parent_reg, next_reg;
  logic [FW-1:0] fill_ptr;
  logic [12:0]   fill_rem;

  // Sequencer working registers.
  logic [8:0]    lo, hi, mid, j;
  logic [AW:0]   clr;
  logic [3:0]    cnt;
  logic [FW-1:0] cur_off, new_off;
  logic [95:0]   hdr;
  rsp_t          res;

  logic [9:0]    mid_sum;
  logic [31:0]   need;
  logic [95:0]   hdr_wr;
  logic          fits;
  rsp_t          res_init;
  rsp_t          rsp_load;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign need    = 32'(HEADER_BYTES) + (32'(lc) + 32'd1) * 32'(SLOT_BYTES)
                 + 32'(CELL_HDR) + 32'(cur.value_len);
  assign fits    = (32'(lc) < 32'(COUNT_CAP)) && (need <= 32'(free_end));
  assign hdr_wr  = {19'd0, cur.value_len, cur.key};

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (heap_we) heap[heap_wa] <= heap_wd;
    heap_q <= heap[heap_ra];
    if (slot_we) slots[slot_wa] <= slot_wd;
    slot_q <= slots[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    heap_we = 1'b0;
    heap_wa = fill_ptr[AW-1:0];
    heap_wd = cur.data_byte;
    heap_ra = AW'(cur_off + FW'(cnt));
    slot_we = 1'b0;
    slot_wa = j[7:0];
    slot_wd = slot_q;
    slot_ra = cur.index;
    unique case (state)
      S_IDLE: if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (cur.action)
          ACT_INIT:   state_next = S_CLEAR;
          ACT_INSERT: state_next = fits ? S_LB_START : S_DONE;
          ACT_VALUE: begin
            heap_we    = (fill_rem != 13'd0);
            state_next = S_DONE;
          end
          ACT_DELETE: state_next = (9'(cur.index) < lc) ? S_SHL : S_DONE;
          ACT_LOWER:  state_next = S_LB_START;
          ACT_READ:   state_next = (9'(cur.index) < lc) ? S_SLOT_WAIT : S_DONE;
          default:    state_next = S_DONE;
        endcase
      end
      S_CLEAR: begin
        heap_we = 1'b1;
        heap_wa = clr[AW-1:0];
        heap_wd = 8'd0;
        if (clr == (AW+1)'(PAGE_BYTES - 1)) state_next = S_DONE;
      end
      S_LB_START: begin
        slot_ra = mid_sum[8:1];
        if (lo < hi)                        state_next = S_SLOT_WAIT;
        else if (cur.action == ACT_INSERT)  state_next = S_HDR_WR;
        else                                state_next = S_DONE;
      end
      S_SLOT_WAIT: state_next = S_FETCH;
      S_FETCH: begin
        if (cnt == 4'(CELL_HDR))
          state_next = (cur.action == ACT_READ) ? S_READ_CHK : S_LB_CMP;
      end
      S_LB_CMP: state_next = S_LB_START;
      S_READ_CHK: begin
        heap_ra = AW'(cur_off + FW'(CELL_HDR) + FW'(cur.byte_offset));
        if (32'(cur.byte_offset) >= hdr[LEN_AT*8 +: 32]) state_next = S_DONE;
        else                                             state_next = S_BYTE_WAIT;
      end
      S_BYTE_WAIT: state_next = S_DONE;
      S_HDR_WR: begin
        heap_we = 1'b1;
        heap_wa = AW'(new_off + FW'(cnt));
        heap_wd = hdr_wr[{cnt, 3'b000} +: 8];
        if (cnt == 4'(CELL_HDR - 1)) state_next = S_SHR;
      end
      S_SHR: begin
        slot_ra = 8'(j - 9'd1);
        if (j > 9'(res.position)) begin
          state_next = S_SHR_WR;
        end else begin
          slot_we    = 1'b1;
          slot_wa    = res.position;
          slot_wd    = new_off;
          state_next = S_DONE;
        end
      end
      S_SHR_WR: begin
        slot_we    = 1'b1;
        state_next = S_SHR;
      end
      S_SHL: begin
        slot_ra = 8'(j + 9'd1);
        if (j + 9'd1 < lc) state_next = S_SHL_WR;
        else               state_next = S_DONE;
      end
      S_SHL_WR: begin
        slot_we    = 1'b1;
        state_next = S_SHL;
      end
      S_DONE: if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Status known at decode; everything else of the result starts at zero.
  always_comb begin
    res_init = '0;
    unique case (cur.action) inside
      ACT_INSERT: if (!fits) res_init.status = ST_NOSPACE;
      ACT_VALUE:  if (fill_rem == 13'd0) res_init.status = ST_NOFILL;
      ACT_DELETE, ACT_READ: if (!(9'(cur.index) < lc)) res_init.status = ST_BADIDX;
      default: ;
    endcase
  end

  // Page state: hold across idle, update where an item commits.
  always_ff @(posedge clk) begin
    if (rst) begin
      lc         <= '0;
      free_end   <= PAGE_END;
      parent_reg <= '0;
      next_reg   <= '0;
      fill_ptr   <= '0;
      fill_rem   <= '0;
    end else begin
      if (state == S_DECODE && cur.action == ACT_VALUE && fill_rem != 13'd0) begin
        fill_ptr <= fill_ptr + FW'(1);
        fill_rem <= fill_rem - 13'd1;
      end
      if (state == S_CLEAR && clr == (AW+1)'(PAGE_BYTES - 1)) begin
        lc         <= '0;
        free_end   <= PAGE_END;
        parent_reg <= cur.parent_page;
        next_reg   <= cur.next_page;
        fill_ptr   <= '0;
        fill_rem   <= '0;
      end
      if (state == S_SHR && !(j > 9'(res.position))) begin
        lc       <= lc + 9'd1;
        free_end <= new_off;
        fill_ptr <= new_off + FW'(CELL_HDR);
        fill_rem <= cur.value_len;
      end
      if (state == S_SHL && !(j + 9'd1 < lc)) lc <= lc - 9'd1;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (req_valid) cur <= req;
      S_DECODE: begin
        res      <= res_init;
        lo       <= '0;
        hi       <= lc;
        clr      <= '0;
        j        <= 9'(cur.index);
        cur_off  <= slot_q;
        new_off  <= FW'(32'(free_end) - 32'(CELL_HDR) - 32'(cur.value_len));
      end
      S_CLEAR: clr <= clr + (AW+1)'(1);
      S_LB_START: begin
        mid          <= 9'(mid_sum[9:1]);
        res.position <= lo[7:0];
        cnt          <= '0;
        j            <= lc;
      end
      S_SLOT_WAIT: begin
        cur_off <= slot_q;
        cnt     <= '0;
      end
      S_FETCH: begin
        if (cnt != 4'd0) hdr <= {heap_q, hdr[95:8]};
        cnt <= cnt + 4'd1;
      end
      S_LB_CMP: begin
        if (hdr[63:0] < cur.key) lo <= mid + 9'd1;
        else                     hi <= mid;
      end
      S_READ_CHK: begin
        res.key_out    <= hdr[63:0];
        res.length_out <= hdr[LEN_AT*8 +: 13];
        if (32'(cur.byte_offset) >= hdr[LEN_AT*8 +: 32]) res.status <= ST_BADIDX;
      end
      S_BYTE_WAIT: res.byte_out <= heap_q;
      S_HDR_WR: cnt <= cnt + 4'd1;
      S_SHR_WR: j <= j - 9'd1;
      S_SHL_WR: j <= j + 9'd1;
      default: ;
    endcase
  end

  // Result beat: item fields plus the page state after the item.
  always_comb begin
    rsp_load             = res;
    rsp_load.entry_count = lc[7:0];
    rsp_load.heap_start  = 13'(free_end);
    rsp_load.parent_out  = parent_reg;
    rsp_load.next_out    = next_reg;
  end

  // Output register: load on completion, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || rsp_ready)) rsp <= rsp_load;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    32'(lc) <= 32'(COUNT_CAP)) else $error("live count above cap");
  a_heap_end: assert property (@(posedge clk) disable iff (rst)
    free_end <= PAGE_END) else $error("heap end beyond page");
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == S_DECODE) else $error("accepted beat not decoded");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !heap_we && !slot_we) else $error("memory write while idle");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_rem != 13'd0 |-> 32'(fill_ptr) + 32'(fill_rem) <= 32'(PAGE_BYTES))
    else $error("pending fill runs past page end");

endmodule

### tb/sv/tb_sorted_slotted_page_store.sv
// Testbench for the sorted slotted page store: directed and random page operations.
module tb_sorted_slotted_page_store;
  timeunit 1ns;
  timeprecision 1ps;
  import sps_pkg::*;

  localparam int PAGE_SZ   = 4096;
  localparam int HDR_SZ    = 17;
  localparam int SLOT_SZ   = 4;
  localparam int COUNT_MAX = 255;
  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  sorted_slotted_page_store uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Mirror of the page contents, kept in the testbench.
  logic [7:0]  page_bytes [PAGE_SZ];
  logic [12:0] slot_off [256];
  int unsigned n_live;
  int unsigned heap_end;
  logic [31:0] parent_mirror, next_mirror;
  int unsigned fill_ptr, fill_left;
  bit page_inited;

  rsp_t pending_rsp [$];
  int   n_errors;
  int   n_beats_in, n_beats_out;
  int   idle_cycles;
  int   send_idle_pct, recv_idle_pct;
  logic [63:0] used_keys [$];

  function automatic logic [63:0] stored_key(int unsigned off);
    logic [63:0] k;
    k = '0;
    for (int b = 7; b >= 0; b--) k = {k[55:0], page_bytes[(off + b) % PAGE_SZ]};
    return k;
  endfunction

  function automatic int unsigned stored_len(int unsigned off);
    int unsigned v;
    v = 0;
    for (int b = 3; b >= 0; b--) v = (v << 8) | page_bytes[(off + 8 + b) % PAGE_SZ];
    return v;
  endfunction

  function automatic int unsigned search_lower(logic [63:0] k);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n_live;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (stored_key(slot_off[mid]) < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one operation to the page mirror and return the expected response.
  function automatic rsp_t apply_page_op(req_t r);
    rsp_t e;
    int unsigned need, new_cell, pos, off, l;
    e = '0;
    case (r.action)
      ACT_INIT: begin
        for (int i = 0; i < PAGE_SZ; i++) page_bytes[i] = 8'h00;
        for (int i = 0; i < 256; i++) slot_off[i] = '0;
        n_live = 0;
        heap_end = PAGE_SZ;
        parent_mirror = r.parent_page;
        next_mirror = r.next_page;
        fill_ptr = 0;
        fill_left = 0;
        page_inited = 1;
      end
      ACT_INSERT: begin
        need = HDR_SZ + (n_live + 1) * SLOT_SZ + CELL_HDR + r.value_len;
        if (n_live >= COUNT_MAX || need > heap_end) begin
          e.status = ST_NOSPACE;
        end else begin
          new_cell = heap_end - CELL_HDR - r.value_len;
          pos = search_lower(r.key);
          for (int b = 0; b < 8; b++)
            page_bytes[(new_cell + b) % PAGE_SZ] = r.key[8*b +: 8];
          for (int b = 0; b < 4; b++)
            page_bytes[(new_cell + 8 + b) % PAGE_SZ] = 8'((32'(r.value_len)) >> (8 * b));
          for (int j = n_live; j > pos; j--) slot_off[j] = slot_off[j-1];
          slot_off[pos] = 13'(new_cell);
          heap_end = new_cell;
          n_live++;
          fill_ptr = new_cell + CELL_HDR;
          fill_left = r.value_len;
          e.position = 8'(pos);
        end
      end
      ACT_VALUE: begin
        if (fill_left == 0) e.status = ST_NOFILL;
        else begin
          page_bytes[fill_ptr % PAGE_SZ] = r.data_byte;
          fill_ptr++;
          fill_left--;
        end
      end
      ACT_DELETE: begin
        if (r.index >= n_live) e.status = ST_BADIDX;
        else begin
          for (int j = r.index; j + 1 < n_live; j++) slot_off[j] = slot_off[j+1];
          n_live--;
        end
      end
      ACT_LOWER: e.position = 8'(search_lower(r.key));
      ACT_READ: begin
        if (r.index >= n_live) e.status = ST_BADIDX;
        else begin
          off = slot_off[r.index];
          l = stored_len(off);
          e.key_out = stored_key(off);
          e.length_out = 13'(l);
          if (r.byte_offset >= l) e.status = ST_BADIDX;
          else e.byte_out = page_bytes[(off + CELL_HDR + r.byte_offset) % PAGE_SZ];
        end
      end
      default: ;
    endcase
    e.entry_count = 8'(n_live);
    e.heap_start  = 13'(heap_end);
    e.parent_out  = parent_mirror;
    e.next_out    = next_mirror;
    return e;
  endfunction

  // Send one beat; the expectation is queued at the accepting edge. Valid drops
  // only while the sender idles, so back-to-back beats keep it high.
  task automatic send_op(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_rsp.push_back(apply_page_op(r));
    n_beats_in++;
    if (r.action == ACT_INSERT) used_keys.push_back(r.key);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  function automatic req_t mk_op(logic [2:0] act);
    req_t r;
    r = '0;
    r.action = act;
    return r;
  endfunction

  task automatic do_init(logic [31:0] par, logic [31:0] nxt);
    req_t r;
    r = mk_op(ACT_INIT);
    r.parent_page = par;
    r.next_page = nxt;
    send_op(r);
  endtask

  // Insert a cell and stream its value bytes.
  task automatic do_insert(logic [63:0] k, int unsigned len, int unsigned fill);
    req_t r;
    r = mk_op(ACT_INSERT);
    r.key = k;
    r.value_len = 13'(len);
    send_op(r);
    for (int i = 0; i < fill; i++) begin
      r = mk_op(ACT_VALUE);
      r.data_byte = 8'($urandom);
      send_op(r);
    end
  endtask

  task automatic do_read(int unsigned idx, int unsigned boff);
    req_t r;
    r = mk_op(ACT_READ);
    r.index = 8'(idx);
    r.byte_offset = 12'(boff);
    send_op(r);
  endtask

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    if (used_keys.size() != 0 && $urandom_range(3) == 0)
      k = used_keys[$urandom_range(used_keys.size() - 1)];
    return k;
  endfunction

  // Check responses in order at the rising edge.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      n_beats_out++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response beat, actual %p", $realtime, rsp);
        n_errors++;
      end else begin
        rsp_t exp_r;
        exp_r = pending_rsp.pop_front();
        if (rsp.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status, rsp.status);
          n_errors++;
        end
        if (rsp.position !== exp_r.position) begin
          $display("%0t: position expected %0d actual %0d", $realtime,
                   exp_r.position, rsp.position);
          n_errors++;
        end
        if (rsp.key_out !== exp_r.key_out) begin
          $display("%0t: key_out expected %h actual %h", $realtime, exp_r.key_out, rsp.key_out);
          n_errors++;
        end
        if (rsp.length_out !== exp_r.length_out) begin
          $display("%0t: length_out expected %0d actual %0d", $realtime,
                   exp_r.length_out, rsp.length_out);
          n_errors++;
        end
        if (rsp.byte_out !== exp_r.byte_out) begin
          $display("%0t: byte_out expected %h actual %h", $realtime,
                   exp_r.byte_out, rsp.byte_out);
          n_errors++;
        end
        if (rsp.entry_count !== exp_r.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $realtime,
                   exp_r.entry_count, rsp.entry_count);
          n_errors++;
        end
        if (rsp.heap_start !== exp_r.heap_start) begin
          $display("%0t: heap_start expected %0d actual %0d", $realtime,
                   exp_r.heap_start, rsp.heap_start);
          n_errors++;
        end
        if (rsp.parent_out !== exp_r.parent_out) begin
          $display("%0t: parent_out expected %h actual %h", $realtime,
                   exp_r.parent_out, rsp.parent_out);
          n_errors++;
        end
        if (rsp.next_out !== exp_r.next_out) begin
          $display("%0t: next_out expected %h actual %h", $realtime,
                   exp_r.next_out, rsp.next_out);
          n_errors++;
        end
      end
    end
  end

  // Toggle rsp_ready at random on the falling edge.
  always @(negedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Directed: fresh init, empty-page errors, value byte with nothing pending, unknown actions.
  task automatic test_empty_page();
    req_t r;
    do_init(32'hFFFF_FFFF, 32'h0000_0000);
    send_op(mk_op(ACT_VALUE));
    r = mk_op(ACT_DELETE);
    send_op(r);
    do_read(0, 0);
    r = mk_op(ACT_LOWER);
    r.key = '1;
    send_op(r);
    send_op(mk_op(3'd6));
    send_op(mk_op(3'd7));
  endtask

  // Directed: key extremes, zero-length cell, abandoned fill, offsets.
  task automatic test_insert_read();
    req_t r;
    do_init(32'h0000_0000, 32'hFFFF_FFFF);
    do_insert(64'hFFFF_FFFF_FFFF_FFFF, 3, 3);
    do_insert(64'h0, 0, 0);
    do_insert(64'h8000_0000_0000_0000, 5, 2);
    do_insert(64'h8000_0000_0000_0000, 2, 2);
    do_read(0, 0);
    do_read(3, 2);
    do_read(3, 3);
    do_read(2, 4095);
    do_read(255, 0);
    r = mk_op(ACT_LOWER);
    r.key = 64'h8000_0000_0000_0000;
    send_op(r);
    r = mk_op(ACT_DELETE);
    r.index = 8'd1;
    send_op(r);
    r.index = 8'd255;
    send_op(r);
  endtask

  // Directed: space limit with a 4096-byte value, then the count cap.
  task automatic test_limits();
    do_init($urandom, $urandom);
    do_insert(64'd5, 4096, 0);
    do_insert(64'd5, 4000, 0);
    do_insert(64'd7, 4000, 0);
    do_init($urandom, $urandom);
    for (int i = 0; i < 260; i++) do_insert({$urandom, $urandom}, 0, 0);
    do_read($urandom_range(254), 0);
  endtask

  // Random: insert/fill sequences, mostly complete, with inits, reads, deletes, lower bounds and noise.
  task automatic test_random(int unsigned count);
    req_t r;
    logic [223:0] noise;
    int unsigned sent, len, sel, fill;
    sent = 0;
    while (sent < count) begin
      sel = $urandom_range(99);
      if (sel < 2) begin
        do_init($urandom, $urandom);
        used_keys.delete();
        sent++;
      end else if (sel < 30) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(6);
        if ($urandom_range(49) == 0) len = $urandom_range(4096);
        if (len > 200) fill = $urandom_range(8);
        else fill = ($urandom_range(7) == 0) ? $urandom_range(len) : len;
        do_insert(rand_key(), len, fill);
        sent += 1 + fill;
      end else if (sel < 55) begin
        r = mk_op(ACT_READ);
        r.index = (n_live != 0 && $urandom_range(5) != 0) ?
                  8'($urandom_range(n_live - 1)) : 8'($urandom);
        r.byte_offset = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(8));
        if (page_inited) begin
          send_op(r);
          sent++;
        end
      end else if (sel < 70) begin
        r = mk_op(ACT_DELETE);
        r.index = (n_live != 0 && $urandom_range(4) != 0) ?
                  8'($urandom_range(n_live - 1)) : 8'($urandom);
        send_op(r);
        sent++;
      end else if (sel < 88) begin
        r = mk_op(ACT_LOWER);
        r.key = rand_key();
        if (page_inited) begin
          send_op(r);
          sent++;
        end
      end else begin
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = noise[$bits(req_t)-1:0];
        if (r.action == ACT_VALUE || r.action >= 3'd6) begin
          send_op(r);
          sent++;
        end
      end
    end
  endtask

  initial begin
    n_errors = 0;
    n_beats_in = 0;
    n_beats_out = 0;
    n_live = 0;
    heap_end = PAGE_SZ;
    parent_mirror = '0;
    next_mirror = '0;
    fill_ptr = 0;
    fill_left = 0;
    page_inited = 0;
    send_idle_pct = 13;
    recv_idle_pct = 47;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_page();
    test_insert_read();
    test_limits();
    test_random(190);
    send_idle_pct = 47;
    recv_idle_pct = 13;
    test_random(190);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(180);

    wait_drain();
    repeat (50) @(negedge clk);
    $display("Covered %0d request beats and %0d response beats over init, insert, fill,",
             n_beats_in, n_beats_out);
    $display("delete, lower bound and read, including space and count limits.");
    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
